### rtl/core/gwm_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// gwm_pkg: shared types and constants of the glob wildcard matcher
// Holds the beat structs, the pattern character codes, the configuration
// register indexes and the sequencer state type.
// ============================================================================
package gwm_pkg;

    // Position registers hold 0..32, so six bits cover every legal position.
    localparam int POS_W      = 6;
    localparam int REG_CHARS  = 32;   // characters the four pattern words can hold
    localparam int WORD_CHARS = 8;    // characters per pattern word
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int DEF_PATTERN_CHARS = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_BASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LAST = 3'd4;

    // Pattern character codes.
    localparam logic [7:0] CH_ANY   = 8'h3F;  // '?'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CH_NOT   = 8'h21;  // '!'

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } t_in_beat;

    typedef struct packed {
        logic matched;
        logic bad_pattern;
    } t_out_beat;

    // Classification of one pattern character against the current text byte.
    typedef struct packed {
        logic is_star;
        logic is_any;
        logic is_open;
        logic is_close;
        logic is_not;
        logic eq_text;
    } t_char_class;

    // Status from the sequencer to the top level.
    typedef struct packed {
        logic idle;
        logic res_valid;
        logic matched;
        logic bad_pattern;
    } t_seq_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_GRP_HEAD,
        ST_GRP_SCAN,
        ST_DONE
    } t_state;

endpackage

### rtl/core/glob_wildcard_matcher.sv
`timescale 1ns / 1ps
// Flow: an accepted text byte goes from idle to the step state, through any extra pattern
//   steps it needs (one per star, one for a group head plus one per group character scanned
//   after it, one per return to the last star) and then to the done state, which loads the
//   result of the last byte into the output register.
// Pacing: the sequencer takes the next byte only after it is back in idle; a stalled result
//   holds the sequencer in the done state until the output register frees.
// Reset: synchronous, active low; clears the pattern registers, the sequencer state, positions and flags.
// ============================================================================
// glob_wildcard_matcher: streaming glob pattern matcher
// Matches a stream of text bytes against a configured glob pattern in one
// greedy pass and reports, on the final byte, whether the pattern was fully
// consumed and whether an unclosed bracket group was met.
// ============================================================================
module glob_wildcard_matcher #(
    parameter int PATTERN_CHARS = gwm_pkg::DEF_PATTERN_CHARS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Text input channel.
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  gwm_pkg::t_in_beat                i_in_data,
    // Result channel.
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output gwm_pkg::t_out_beat               o_out_data,
    // Configuration write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gwm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gwm_pkg::*;

    // The block takes a text beat only while the sequencer is idle. Each beat then
    // runs through the pattern one character per cycle: the sequencer presents a
    // pattern address, the store returns that character, and the shared compare
    // unit classifies it against the text byte. A result beat is produced only for
    // the beat marked as last; it lands in an output register so the sequencer can
    // take the next text beat while the result waits downstream.

    logic              cfg_we;
    logic              cfg_clear;
    logic [POS_W-1:0]  rd_addr;
    logic [7:0]        rd_char;
    logic [7:0]        text_char;
    logic [POS_W-1:0]  eff_len;
    t_char_class       char_class;
    t_seq_status       status;
    logic              out_free;

    logic              r_out_valid;
    t_out_beat         r_out_data;

    // Configuration is taken only while no text beat is in flight.
    assign o_cfg_ready = status.idle;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    gwm_pattern_store #(
        .PATTERN_CHARS(PATTERN_CHARS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_rd_addr  (rd_addr),
        .o_rd_char  (rd_char),
        .o_eff_len  (eff_len),
        .o_cfg_clear(cfg_clear)
    );

    gwm_char_unit u_char (
        .i_pat_char (rd_char),
        .i_text_char(text_char),
        .o_class    (char_class)
    );

    gwm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_out_free (out_free),
        .i_cfg_clear(cfg_clear),
        .i_eff_len  (eff_len),
        .i_class    (char_class),
        .o_rd_addr  (rd_addr),
        .o_text_char(text_char),
        .o_status   (status)
    );

    assign o_in_stall = !status.idle;

    // The output register can take a new result when it is empty or being drained.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (status.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.res_valid) begin
            r_out_data.matched     <= status.matched;
            r_out_data.bad_pattern <= status.bad_pattern;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

`ifndef ASSERT_OFF
    // The sequencer is always busy in the cycle after it accepts a text beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer ready right after accepting a text beat");

    // An unclosed group always fails the match.
    a_bad_never_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.matched && o_out_data.bad_pattern))
        else $error("result reports a match on a malformed pattern");

    // A new result is never loaded over one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !status.res_valid)
        else $error("result overwritten while stalled");
`endif

endmodule

### rtl/core/gwm_pattern_store.sv
`timescale 1ns / 1ps
// ============================================================================
// gwm_pattern_store: pattern registers and character read port
// Holds the pattern length and characters, decodes configuration writes and
// serves one pattern character per cycle at the address the sequencer gives.
// ============================================================================
module gwm_pattern_store #(
    parameter int PATTERN_CHARS = gwm_pkg::DEF_PATTERN_CHARS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gwm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gwm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [gwm_pkg::POS_W-1:0]        i_rd_addr,
    output logic [7:0]                       o_rd_char,
    output logic [gwm_pkg::POS_W-1:0]        o_eff_len,
    output logic                             o_cfg_clear
);
    import gwm_pkg::*;

    localparam int STORE_CHARS = (PATTERN_CHARS < REG_CHARS) ? PATTERN_CHARS : REG_CHARS;
    localparam int IDX_W       = $clog2(STORE_CHARS);
    localparam logic [POS_W-1:0] STORE_LEN = POS_W'(STORE_CHARS);

    logic [POS_W-1:0] r_len;
    logic [7:0]       r_chars [STORE_CHARS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_we && (i_cfg_index == CFG_LEN)) begin
            r_len <= i_cfg_data[POS_W-1:0];
        end
    end

    // Each pattern word carries eight characters, character 0 in the low byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STORE_CHARS; k++) begin
                r_chars[k] <= '0;
            end
        end else if (i_cfg_we) begin
            for (int k = 0; k < STORE_CHARS; k++) begin
                if (i_cfg_index == (CFG_CHARS_BASE + CFG_IDX_W'(k / WORD_CHARS))) begin
                    r_chars[k] <= i_cfg_data[(k % WORD_CHARS) * 8 +: 8];
                end
            end
        end
    end

    always_comb begin
        if (i_rd_addr < STORE_LEN) begin
            o_rd_char = r_chars[i_rd_addr[IDX_W-1:0]];
        end else begin
            o_rd_char = '0;
        end
    end

    assign o_eff_len   = (r_len > STORE_LEN) ? STORE_LEN : r_len;
    assign o_cfg_clear = i_cfg_we && (i_cfg_index <= CFG_CHARS_LAST);

endmodule

### rtl/core/gwm_char_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// gwm_char_unit: shared pattern character compare unit
// Classifies the pattern character under the read pointer and compares it
// with the text byte being matched.
// ============================================================================
module gwm_char_unit (
    input  logic [7:0]           i_pat_char,
    input  logic [7:0]           i_text_char,
    output gwm_pkg::t_char_class o_class
);
    import gwm_pkg::*;

    always_comb begin
        o_class.is_star  = (i_pat_char == CH_STAR);
        o_class.is_any   = (i_pat_char == CH_ANY);
        o_class.is_open  = (i_pat_char == CH_OPEN);
        o_class.is_close = (i_pat_char == CH_CLOSE);
        o_class.is_not   = (i_pat_char == CH_NOT);
        o_class.eq_text  = (i_pat_char == i_text_char);
    end

endmodule

### rtl/core/gwm_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// gwm_seq: matching sequencer
// Walks the pattern one character per cycle for each text byte: star skips,
// bracket group scans and the return to the last star, then reports the
// result on the final byte of the text.
// ============================================================================
module gwm_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  gwm_pkg::t_in_beat             i_in_data,
    input  logic                          i_out_free,
    input  logic                          i_cfg_clear,
    input  logic [gwm_pkg::POS_W-1:0]     i_eff_len,
    input  gwm_pkg::t_char_class          i_class,
    output logic [gwm_pkg::POS_W-1:0]     o_rd_addr,
    output logic [7:0]                    o_text_char,
    output gwm_pkg::t_seq_status          o_status
);
    import gwm_pkg::*;

    t_state           r_state,     n_state;
    logic [POS_W-1:0] r_pos,       n_pos;
    logic [POS_W-1:0] r_star_pos,  n_star_pos;
    logic             r_star_seen, n_star_seen;
    logic             r_after_star, n_after_star;
    logic             r_failed,    n_failed;
    logic             r_malformed, n_malformed;
    logic [7:0]       r_char,      n_char;
    logic             r_last,      n_last;
    logic [POS_W-1:0] r_idx,       n_idx;
    logic             r_hit,       n_hit;
    logic             r_invert,    n_invert;

    logic accept;
    logic at_end;
    logic grp_end;
    logic step_live;
    logic step_hit;
    logic grp_close;
    logic grp_match;
    logic miss;
    logic retry;
    logic emit;

    assign accept    = (r_state == ST_IDLE) && i_in_valid;
    assign at_end    = (r_pos >= i_eff_len);
    assign grp_end   = (r_idx >= i_eff_len);
    assign step_live = (r_state == ST_STEP) && !r_failed && !at_end;
    assign step_hit  = step_live && !i_class.is_star && !i_class.is_open
                     && (i_class.is_any || i_class.eq_text);
    assign grp_close = (r_state == ST_GRP_SCAN) && !grp_end && i_class.is_close;
    assign grp_match = (r_hit != r_invert);
    assign miss      = (step_live && !i_class.is_star && !i_class.is_open && !step_hit)
                     || (grp_close && !grp_match);
    assign retry     = !r_after_star && r_star_seen;
    assign emit      = (r_state == ST_DONE) && r_last && i_out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (!step_live) begin
                    n_state = ST_DONE;
                end else if (i_class.is_star) begin
                    n_state = ST_STEP;
                end else if (i_class.is_open) begin
                    n_state = ST_GRP_HEAD;
                end else if (step_hit) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = retry ? ST_STEP : ST_DONE;
                end
            end
            ST_GRP_HEAD: begin
                n_state = grp_end ? ST_DONE : ST_GRP_SCAN;
            end
            ST_GRP_SCAN: begin
                if (grp_end) begin
                    n_state = ST_DONE;
                end else if (grp_close) begin
                    n_state = (grp_match || !retry) ? ST_DONE : ST_STEP;
                end
            end
            ST_DONE: begin
                if (!r_last || i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Matching state and scan registers.
    always_comb begin
        n_pos        = r_pos;
        n_star_pos   = r_star_pos;
        n_star_seen  = r_star_seen;
        n_after_star = r_after_star;
        n_failed     = r_failed;
        n_malformed  = r_malformed;
        n_char       = r_char;
        n_last       = r_last;
        n_idx        = r_idx;
        n_hit        = r_hit;
        n_invert     = r_invert;

        if (accept) begin
            n_char = i_in_data.text_char;
            n_last = i_in_data.last_char;
        end

        if (step_live && i_class.is_star) begin
            n_star_pos   = r_pos;
            n_star_seen  = 1'b1;
            n_after_star = 1'b1;
            n_pos        = r_pos + 1'b1;
        end
        if (step_live && i_class.is_open) begin
            n_idx    = r_pos + 1'b1;
            n_hit    = 1'b0;
            n_invert = 1'b0;
        end
        if (step_hit) begin
            n_pos        = r_pos + 1'b1;
            n_after_star = 1'b0;
        end

        if (r_state == ST_GRP_HEAD) begin
            if (grp_end) begin
                n_failed    = 1'b1;
                n_malformed = 1'b1;
            end else if (i_class.is_close) begin
                // A leading ']' is a member of the group.
                n_hit = i_class.eq_text;
                n_idx = r_idx + 1'b1;
            end else if (i_class.is_not) begin
                n_invert = 1'b1;
                n_idx    = r_idx + 1'b1;
            end
        end

        if (r_state == ST_GRP_SCAN) begin
            if (grp_end) begin
                n_failed    = 1'b1;
                n_malformed = 1'b1;
            end else if (grp_close) begin
                if (grp_match) begin
                    n_pos        = r_idx + 1'b1;
                    n_after_star = 1'b0;
                end
            end else begin
                if (i_class.eq_text) begin
                    n_hit = 1'b1;
                end
                n_idx = r_idx + 1'b1;
            end
        end

        // A mismatch right after a star just consumes the byte into the star.
        if (miss && !r_after_star) begin
            if (r_star_seen) begin
                n_pos = r_star_pos;
            end else begin
                n_failed = 1'b1;
            end
        end

        if (emit || i_cfg_clear) begin
            n_pos        = '0;
            n_star_pos   = '0;
            n_star_seen  = 1'b0;
            n_after_star = 1'b0;
            n_failed     = 1'b0;
            n_malformed  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_star_pos   <= '0;
            r_star_seen  <= 1'b0;
            r_after_star <= 1'b0;
            r_failed     <= 1'b0;
            r_malformed  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_star_pos   <= n_star_pos;
            r_star_seen  <= n_star_seen;
            r_after_star <= n_after_star;
            r_failed     <= n_failed;
            r_malformed  <= n_malformed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char   <= n_char;
        r_last   <= n_last;
        r_idx    <= n_idx;
        r_hit    <= n_hit;
        r_invert <= n_invert;
    end

    // Outputs.
    always_comb begin
        o_rd_addr            = (r_state == ST_STEP) ? r_pos : r_idx;
        o_text_char          = r_char;
        o_status.idle        = (r_state == ST_IDLE);
        o_status.res_valid   = emit;
        o_status.matched     = !r_failed && at_end;
        o_status.bad_pattern = r_malformed;
    end

endmodule
